// File: rtl/trial_division_prime_test_unit_macros.svh
// assertion macros for the trial division prime test unit
// no dependencies; included by the top level only
`ifndef TRIAL_DIVISION_PRIME_TEST_UNIT_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define TDPT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdpt assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define TDPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdpt assertion failed");
`else
`define TDPT_ASSERT_IMPL(label, ante, cons)
`define TDPT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/tdpt_pkg.sv
// constants shared by the trial division prime test unit
// no dependencies
package tdpt_pkg;

    // default candidate width
    localparam int VALUE_BITS_DEF = 17;

    // dividend bits retired by the remainder unit in one cycle
    localparam int STEP_BITS = 8;

    // small values with fixed answers
    localparam int SMALL_PRIME_TWO   = 2;
    localparam int SMALL_PRIME_THREE = 3;

    // first trial divisor and its square
    localparam int FIRST_DIVISOR = 3;
    localparam int FIRST_SQUARE  = 9;

    // wheel steps over divisors coprime to six
    localparam int STEP_SHORT = 2;
    localparam int STEP_LONG  = 4;

endpackage

// File: rtl/trial_division_prime_test_unit.sv
// trial division prime test: 0, 1, 2, 3 and even values are answered straight from idle;
// other values are tried against divisors 3, 5, 7, 11, 13, ... with a bound check (divisor
// square past the candidate) before each, each division taking CHUNKS = ceil(VALUE_BITS/
// STEP_BITS) steps of the shared remainder unit (STEP_BITS dividend bits a cycle);
// one beat in flight, next beat accepted in the cycle after the result beat is taken;
// rst_n is asynchronous and returns to idle; uses tdpt_pkg and the assertion macro header
`include "trial_division_prime_test_unit_macros.svh"

module trial_division_prime_test_unit
    import tdpt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [VALUE_BITS-1:0] candidate,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  prime_flag
);

    // divisor, square and remainder widths with headroom for the last step
    localparam int D_W    = VALUE_BITS + 1;
    localparam int SQ_W   = VALUE_BITS + 4;
    localparam int CHUNKS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W  = CHUNKS * STEP_BITS;
    localparam int CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic                  prime_flag_reg, prime_flag_next;
    logic [VALUE_BITS-1:0] cand_reg, cand_next;
    logic [D_W-1:0]        d_reg, d_next;
    logic [SQ_W-1:0]       sq_reg, sq_next;
    logic [D_W-1:0]        rem_reg, rem_next;
    logic [PAD_W-1:0]      shift_reg, shift_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  first_reg, first_next;
    logic                  four_reg, four_next;

    logic [D_W-1:0]        rem_step;
    logic                  step_long;
    logic                  last_chunk;

    // shared remainder unit: restoring division, STEP_BITS bits per cycle
    always_comb
    begin
        logic [D_W:0] r;
        r = {1'b0, rem_reg};
        for (int i = 0; i < STEP_BITS; i++)
        begin
            r = {r[D_W-1:0], shift_reg[PAD_W-1-i]};
            if (r >= {1'b0, d_reg})
            begin
                r = r - {1'b0, d_reg};
            end
        end
        rem_step = r[D_W-1:0];
    end

    assign step_long  = !first_reg && four_reg;
    assign last_chunk = (cnt_reg == CNT_W'(CHUNKS - 1));

    // sequencer and datapath next values
    always_comb
    begin
        state_next      = state_reg;
        prime_flag_next = prime_flag_reg;
        cand_next       = cand_reg;
        d_next          = d_reg;
        sq_next         = sq_reg;
        rem_next        = rem_reg;
        shift_next      = shift_reg;
        cnt_next        = cnt_reg;
        first_next      = first_reg;
        four_next       = four_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cand_next  = candidate;
                    d_next     = D_W'(FIRST_DIVISOR);
                    sq_next    = SQ_W'(FIRST_SQUARE);
                    first_next = 1'b1;
                    four_next  = 1'b0;
                    if (candidate < VALUE_BITS'(SMALL_PRIME_TWO))
                    begin
                        prime_flag_next = 1'b0;
                        state_next      = ST_DONE;
                    end
                    else if (candidate == VALUE_BITS'(SMALL_PRIME_TWO) ||
                             candidate == VALUE_BITS'(SMALL_PRIME_THREE))
                    begin
                        prime_flag_next = 1'b1;
                        state_next      = ST_DONE;
                    end
                    else if (!candidate[0])
                    begin
                        prime_flag_next = 1'b0;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                // divisor square past the candidate: no factor left
                if (sq_reg > SQ_W'(cand_reg))
                begin
                    prime_flag_next = 1'b1;
                    state_next      = ST_DONE;
                end
                else
                begin
                    rem_next   = '0;
                    shift_next = PAD_W'(cand_reg);
                    cnt_next   = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                rem_next   = rem_step;
                shift_next = shift_reg << STEP_BITS;
                cnt_next   = cnt_reg + CNT_W'(1);
                if (last_chunk)
                begin
                    if (rem_step == '0)
                    begin
                        prime_flag_next = 1'b0;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        // next divisor coprime to six, square kept by adds
                        if (step_long)
                        begin
                            d_next  = d_reg + D_W'(STEP_LONG);
                            sq_next = sq_reg + (SQ_W'(d_reg) << 3) +
                                      SQ_W'(STEP_LONG * STEP_LONG);
                        end
                        else
                        begin
                            d_next  = d_reg + D_W'(STEP_SHORT);
                            sq_next = sq_reg + (SQ_W'(d_reg) << 2) +
                                      SQ_W'(STEP_SHORT * STEP_SHORT);
                        end
                        first_next = 1'b0;
                        four_next  = first_reg ? 1'b0 : !four_reg;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prime_flag_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prime_flag_reg <= prime_flag_next;
        end
    end

    // datapath registers, loaded before use
    always_ff @(posedge clk)
    begin
        cand_reg  <= cand_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        cnt_reg   <= cnt_next;
        first_reg <= first_next;
        four_reg  <= four_next;
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = (state_reg == ST_DONE);
    assign prime_flag = prime_flag_reg;

    // accepted beat keeps the input side busy
    `TDPT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    // trial divisors are always odd
    `TDPT_ASSERT_IMPL(a_divisor_odd, state_reg == ST_DIVIDE, d_reg[0])
    // a prime answer never comes for zero or one
    `TDPT_ASSERT_IMPL(a_prime_at_least_two, out_valid && prime_flag,
                      cand_reg >= VALUE_BITS'(SMALL_PRIME_TWO))

endmodule
